// ===== rtl/alpha_blend_rect_fill_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the alpha blend rectangle fill block
// Concurrent property wrappers clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ALPHA_BLEND_RECT_FILL_ASSERT_SVH
`define ALPHA_BLEND_RECT_FILL_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ABRF_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent ends.
`define ABRF_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/abrf_pkg.sv =====
// ----------------------------------------------------------------------------
// abrf_pkg
// Widths, register indexes and the channel blend function of the alpha
// blend rectangle fill block.
// ----------------------------------------------------------------------------
`default_nettype none

package abrf_pkg;

   localparam int unsigned FB_PITCH     = 4096;
   localparam int unsigned COORD_W      = 12;
   localparam int unsigned PIXEL_W      = 32;
   localparam int unsigned ADDR_W       = 24;
   localparam int unsigned SPAN_W       = 18;
   localparam int unsigned FRAME_W      = 13;
   localparam int unsigned REQ_DATA_W   = 56;
   localparam int unsigned RSP_DATA_W   = 56;
   localparam int unsigned CSR_INDEX_W  = 3;
   localparam int unsigned CSR_DATA_W   = 32;

   localparam logic [7:0] ALPHA_CLEAR  = 8'h00;
   localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
   localparam logic [7:0] CHANNEL_MAX  = 8'd255;
   localparam logic [7:0] ROUND_BIAS   = 8'd127;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_RECT_X       = 3'd0,
      CSR_RECT_Y       = 3'd1,
      CSR_RECT_WIDTH   = 3'd2,
      CSR_RECT_HEIGHT  = 3'd3,
      CSR_FRAME_WIDTH  = 3'd4,
      CSR_FRAME_HEIGHT = 3'd5,
      CSR_FILL_COLOR   = 3'd6,
      CSR_BLEND_ALPHA  = 3'd7
   } csr_index_type;

   // Rounded blend of one channel divided by 255. The division uses
   // floor(v / 255) = (v + 1 + (v >> 8)) >> 8, exact for all v below 65535.
   function automatic logic [7:0] mix8(input logic [7:0] src, input logic [7:0] dst,
                                       input logic [7:0] alpha);
      logic [7:0]  inv;
      logic [16:0] sum;
      logic [16:0] quo;
      inv = CHANNEL_MAX - alpha;
      sum = 17'({8'd0, src} * {8'd0, alpha}) + 17'({8'd0, dst} * {8'd0, inv})
            + {9'd0, ROUND_BIAS};
      quo = sum + 17'd1 + (sum >> 8);
      return quo[15:8];
   endfunction

endpackage

`default_nettype wire

// ===== rtl/alpha_blend_rect_fill.sv =====
// Pipeline: the input register, the blend and clip logic and the result register
// form a two-register pipeline; an accepted pixel word moves on from the input
// register into the result register when the result side does not stall.
// Throughput: one pixel word per cycle while the result side does not stall.
// Reset: synchronous, active high; it clears both valid bits and sets every
// configuration register to zero.
// ----------------------------------------------------------------------------
// alpha_blend_rect_fill
// Clips each pixel against the fill rectangle and the frame, blends the fill
// color into it by the configured alpha and reports the word address.
// ----------------------------------------------------------------------------
`default_nettype none

module alpha_blend_rect_fill (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_tvalid,
   output      logic                                 req_tready,
   // pixel_x [11:0], pixel_y [23:12], dst_pixel [55:24]
   input  wire logic [abrf_pkg::REQ_DATA_W-1:0]      req_tdata,
   output      logic                                 rsp_tvalid,
   input  wire logic                                 rsp_tready,
   // new_pixel [31:0], word_address [55:32]
   output      logic [abrf_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // write_enable [0]
   output      logic                                 rsp_tuser,
   input  wire logic                                 csr_valid,
   output      logic                                 csr_ready,
   input  wire logic [abrf_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [abrf_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   logic signed [15:0]                     rect_x_ff;
   logic signed [15:0]                     rect_y_ff;
   logic [15:0]                            rect_width_ff;
   logic [15:0]                            rect_height_ff;
   logic [abrf_pkg::FRAME_W-1:0]           frame_width_ff;
   logic [abrf_pkg::FRAME_W-1:0]           frame_height_ff;
   logic [abrf_pkg::PIXEL_W-1:0]           fill_color_ff;
   logic [7:0]                             blend_alpha_ff;

   logic                                   s1_valid_ff;
   logic                                   s1_valid_in;
   logic [abrf_pkg::COORD_W-1:0]           s1_px_ff;
   logic [abrf_pkg::COORD_W-1:0]           s1_py_ff;
   logic [abrf_pkg::PIXEL_W-1:0]           s1_dst_ff;

   logic                                   rsp_valid_ff;
   logic                                   rsp_valid_in;
   logic                                   rsp_we_ff;
   logic                                   rsp_we_in;
   logic [abrf_pkg::PIXEL_W-1:0]           rsp_pixel_ff;
   logic [abrf_pkg::PIXEL_W-1:0]           rsp_pixel_in;
   logic [abrf_pkg::ADDR_W-1:0]            rsp_addr_ff;
   logic [abrf_pkg::ADDR_W-1:0]            rsp_addr_in;

   logic                                   advance;
   logic                                   req_accept;
   logic signed [abrf_pkg::SPAN_W-1:0]     pos_x;
   logic signed [abrf_pkg::SPAN_W-1:0]     pos_y;
   logic signed [abrf_pkg::SPAN_W-1:0]     lo_x;
   logic signed [abrf_pkg::SPAN_W-1:0]     lo_y;
   logic signed [abrf_pkg::SPAN_W-1:0]     hi_x;
   logic signed [abrf_pkg::SPAN_W-1:0]     hi_y;
   logic                                   in_x;
   logic                                   in_y;
   logic                                   in_rect;
   logic [7:0]                             mix_r;
   logic [7:0]                             mix_g;
   logic [7:0]                             mix_b;

   assign csr_ready  = 1'b1;
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = !s1_valid_ff || advance;
   assign req_accept = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rect_x_ff       <= '0;
         rect_y_ff       <= '0;
         rect_width_ff   <= '0;
         rect_height_ff  <= '0;
         frame_width_ff  <= '0;
         frame_height_ff <= '0;
         fill_color_ff   <= '0;
         blend_alpha_ff  <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            abrf_pkg::CSR_RECT_X:       rect_x_ff       <= csr_wdata[15:0];
            abrf_pkg::CSR_RECT_Y:       rect_y_ff       <= csr_wdata[15:0];
            abrf_pkg::CSR_RECT_WIDTH:   rect_width_ff   <= csr_wdata[15:0];
            abrf_pkg::CSR_RECT_HEIGHT:  rect_height_ff  <= csr_wdata[15:0];
            abrf_pkg::CSR_FRAME_WIDTH:  frame_width_ff  <= csr_wdata[abrf_pkg::FRAME_W-1:0];
            abrf_pkg::CSR_FRAME_HEIGHT: frame_height_ff <= csr_wdata[abrf_pkg::FRAME_W-1:0];
            abrf_pkg::CSR_FILL_COLOR:   fill_color_ff   <= csr_wdata;
            abrf_pkg::CSR_BLEND_ALPHA:  blend_alpha_ff  <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   assign s1_valid_in = req_tready ? req_tvalid : s1_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_px_ff  <= req_tdata[11:0];
         s1_py_ff  <= req_tdata[23:12];
         s1_dst_ff <= req_tdata[55:24];
      end
   end

   always_comb begin
      pos_x  = abrf_pkg::SPAN_W'({6'd0, s1_px_ff});
      pos_y  = abrf_pkg::SPAN_W'({6'd0, s1_py_ff});
      lo_x   = abrf_pkg::SPAN_W'(rect_x_ff);
      lo_y   = abrf_pkg::SPAN_W'(rect_y_ff);
      hi_x   = lo_x + $signed({2'd0, rect_width_ff});
      hi_y   = lo_y + $signed({2'd0, rect_height_ff});
      in_x   = (pos_x >= lo_x) && (pos_x < hi_x)
               && ({1'b0, s1_px_ff} < frame_width_ff);
      in_y   = (pos_y >= lo_y) && (pos_y < hi_y)
               && ({1'b0, s1_py_ff} < frame_height_ff);
      in_rect = (rect_width_ff != '0) && (rect_height_ff != '0) && in_x && in_y;

      mix_r = abrf_pkg::mix8(fill_color_ff[23:16], s1_dst_ff[23:16], blend_alpha_ff);
      mix_g = abrf_pkg::mix8(fill_color_ff[15:8], s1_dst_ff[15:8], blend_alpha_ff);
      mix_b = abrf_pkg::mix8(fill_color_ff[7:0], s1_dst_ff[7:0], blend_alpha_ff);

      rsp_we_in    = in_rect && (blend_alpha_ff != abrf_pkg::ALPHA_CLEAR);
      rsp_pixel_in = s1_dst_ff;
      if (rsp_we_in) begin
         if (blend_alpha_ff == abrf_pkg::ALPHA_OPAQUE) begin
            rsp_pixel_in = fill_color_ff;
         end else begin
            rsp_pixel_in = {8'd0, mix_r, mix_g, mix_b};
         end
      end

      rsp_addr_in = abrf_pkg::ADDR_W'(({12'd0, s1_py_ff}
                    * abrf_pkg::ADDR_W'(abrf_pkg::FB_PITCH)) + {12'd0, s1_px_ff});
   end

   assign rsp_valid_in = advance ? s1_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && s1_valid_ff) begin
         rsp_we_ff    <= rsp_we_in;
         rsp_pixel_ff <= rsp_pixel_in;
         rsp_addr_ff  <= rsp_addr_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_we_ff;
   assign rsp_tdata  = {rsp_addr_ff, rsp_pixel_ff};

endmodule

`default_nettype wire

// ===== rtl/abrf_checker.sv =====
// ----------------------------------------------------------------------------
// abrf_checker
// Port-level checks of the alpha blend rectangle fill block: result hold under
// stall, pipeline latency and the source of input back pressure.
// ----------------------------------------------------------------------------
`default_nettype none

`include "alpha_blend_rect_fill_assert.svh"

module abrf_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              req_tvalid,
   input wire logic                              req_tready,
   input wire logic                              rsp_tvalid,
   input wire logic                              rsp_tready,
   input wire logic [abrf_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input wire logic                              rsp_tuser
);

   `ABRF_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "Stalled result word changed.")

   `ABRF_ASSERT_NEXT(a_rsp_latency, req_tvalid && req_tready ##1 rsp_tready, rsp_tvalid, "Accepted pixel did not reach the result register.")

   `ABRF_ASSERT_NOW(a_backpressure, !req_tready, rsp_tvalid && !rsp_tready, "Input stalled while the result side was free.")

endmodule

bind alpha_blend_rect_fill abrf_checker u_abrf_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the alpha blend rectangle fill block. Pixel words
// go in on the request stream, and a predictor works out the write flag, the
// new pixel and the word address for each accepted word. Results are compared
// in order, field by field. Directed cases cover clipping edges, zero sizes,
// extreme geometry and every alpha mode, then random fill setups with random
// sender bursts and receiver stalls follow.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 200000;

   typedef struct {
      logic [15:0] rect_x;
      logic [15:0] rect_y;
      logic [15:0] rect_w;
      logic [15:0] rect_h;
      logic [12:0] frame_w;
      logic [12:0] frame_h;
      logic [31:0] color;
      logic [7:0]  alpha;
   } fill_setup_type;

   typedef struct {
      logic                        write_enable;
      logic [31:0]                 new_pixel;
      logic [abrf_pkg::ADDR_W-1:0] address;
   } pixel_result_type;

   typedef enum {RX_ALWAYS, RX_PATTERN, RX_RANDOM} rx_style_type;

   logic                             clock;
   logic                             reset = 1'b1;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [abrf_pkg::REQ_DATA_W-1:0]  req_tdata = '0;
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [abrf_pkg::RSP_DATA_W-1:0]  rsp_tdata;
   logic                             rsp_tuser;
   logic                             csr_valid = 1'b0;
   logic                             csr_ready;
   logic [abrf_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [abrf_pkg::CSR_DATA_W-1:0]  csr_wdata = '0;

   fill_setup_type   fill_regs = '{default: '0};
   pixel_result_type blend_queue[$];
   pixel_result_type oldest;
   rx_style_type     rx_style = RX_ALWAYS;
   logic [15:0]      ready_pattern = 16'hB6DB;
   bit               tx_bursty = 1'b0;
   int               burst_left = 0;
   int               cycle_count = 0;
   int               error_count = 0;
   int               pixels_sent = 0;
   int               fill_setups = 0;
   int               writes_seen = 0;
   int               blends_seen = 0;
   int               opaque_seen = 0;

   alpha_blend_rect_fill u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic bit span_hit(int pos, int lo, int len, int lim);
      int first;
      int stop;
      first = (lo < 0) ? 0 : lo;
      stop = lo + len;
      if (stop > lim) stop = lim;
      return (pos >= first) && (pos < stop);
   endfunction

   function automatic logic [7:0] mix_channel(int unsigned s, int unsigned d, int unsigned a);
      return 8'((s * a + d * (255 - a) + 127) / 255);
   endfunction

   function automatic pixel_result_type blend_pixel(logic [11:0] px, logic [11:0] py,
                                                    logic [31:0] dst);
      pixel_result_type r;
      bit hit;
      hit = fill_regs.rect_w != 0 && fill_regs.rect_h != 0 &&
            span_hit(px, $signed(fill_regs.rect_x), fill_regs.rect_w, fill_regs.frame_w) &&
            span_hit(py, $signed(fill_regs.rect_y), fill_regs.rect_h, fill_regs.frame_h);
      r.address = abrf_pkg::ADDR_W'(py * abrf_pkg::FB_PITCH + px);
      r.write_enable = 1'b0;
      r.new_pixel = dst;
      if (hit && fill_regs.alpha != abrf_pkg::ALPHA_CLEAR) begin
         r.write_enable = 1'b1;
         if (fill_regs.alpha == abrf_pkg::ALPHA_OPAQUE) begin
            r.new_pixel = fill_regs.color;
         end else begin
            r.new_pixel = {8'h00,
                           mix_channel(fill_regs.color[23:16], dst[23:16], fill_regs.alpha),
                           mix_channel(fill_regs.color[15:8], dst[15:8], fill_regs.alpha),
                           mix_channel(fill_regs.color[7:0], dst[7:0], fill_regs.alpha)};
         end
      end
      return r;
   endfunction

   function automatic fill_setup_type make_setup(int x, int y, int w, int h, int fw, int fh,
                                                 logic [31:0] color, logic [7:0] alpha);
      fill_setup_type s;
      s.rect_x = 16'(x);
      s.rect_y = 16'(y);
      s.rect_w = 16'(w);
      s.rect_h = 16'(h);
      s.frame_w = 13'(fw);
      s.frame_h = 13'(fh);
      s.color = color;
      s.alpha = alpha;
      return s;
   endfunction

   function automatic logic [15:0] random_extent();
      case ($urandom_range(0, 9))
         0: return 16'd0;
         1: return 16'($urandom());
         2: return 16'hFFFF;
         default: return 16'($urandom_range(1, 200));
      endcase
   endfunction

   function automatic logic [12:0] random_frame();
      case ($urandom_range(0, 9))
         0: return 13'd4096;
         1: return 13'h1FFF;
         2: return 13'($urandom());
         3: return 13'd0;
         default: return 13'($urandom_range(16, 300));
      endcase
   endfunction

   function automatic fill_setup_type random_setup();
      fill_setup_type s;
      if ($urandom_range(0, 7) == 0) begin
         s.rect_x = 16'($urandom());
         s.rect_y = 16'($urandom());
      end else begin
         s.rect_x = 16'($urandom_range(0, 400) - 40);
         s.rect_y = 16'($urandom_range(0, 400) - 40);
      end
      s.rect_w = random_extent();
      s.rect_h = random_extent();
      s.frame_w = random_frame();
      s.frame_h = random_frame();
      s.color = $urandom();
      case ($urandom_range(0, 9))
         0: s.alpha = abrf_pkg::ALPHA_CLEAR;
         1, 2: s.alpha = abrf_pkg::ALPHA_OPAQUE;
         3: s.alpha = 8'd1;
         4: s.alpha = 8'd254;
         default: s.alpha = 8'($urandom());
      endcase
      return s;
   endfunction

   // Picks a coordinate in or just around the clipped span, or anywhere when it is empty.
   function automatic logic [11:0] near_span(logic [15:0] lo_bits, logic [15:0] len,
                                             logic [12:0] lim);
      int lo;
      int first;
      int stop;
      int low_pick;
      int high_pick;
      lo = $signed(lo_bits);
      first = (lo < 0) ? 0 : lo;
      stop = lo + len;
      if (stop > lim) stop = lim;
      if (stop <= first || first > 4095) return 12'($urandom());
      low_pick = (first >= 2) ? first - 2 : 0;
      high_pick = (stop + 1 > 4095) ? 4095 : stop + 1;
      return 12'($urandom_range(low_pick, high_pick));
   endfunction

   task automatic flag_mismatch(input string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      error_count++;
   endtask

   task automatic write_reg(input abrf_pkg::csr_index_type idx, input logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         abrf_pkg::CSR_RECT_X:       fill_regs.rect_x = data[15:0];
         abrf_pkg::CSR_RECT_Y:       fill_regs.rect_y = data[15:0];
         abrf_pkg::CSR_RECT_WIDTH:   fill_regs.rect_w = data[15:0];
         abrf_pkg::CSR_RECT_HEIGHT:  fill_regs.rect_h = data[15:0];
         abrf_pkg::CSR_FRAME_WIDTH:  fill_regs.frame_w = data[12:0];
         abrf_pkg::CSR_FRAME_HEIGHT: fill_regs.frame_h = data[12:0];
         abrf_pkg::CSR_FILL_COLOR:   fill_regs.color = data;
         abrf_pkg::CSR_BLEND_ALPHA:  fill_regs.alpha = data[7:0];
         default: ;
      endcase
   endtask

   // Unused upper bits of each register word carry random junk half the time.
   task automatic configure(input fill_setup_type s);
      logic [31:0] junk;
      junk = $urandom_range(0, 1) ? $urandom() : 32'd0;
      write_reg(abrf_pkg::CSR_RECT_X, {junk[31:16], s.rect_x});
      write_reg(abrf_pkg::CSR_RECT_Y, {junk[31:16], s.rect_y});
      write_reg(abrf_pkg::CSR_RECT_WIDTH, {junk[31:16], s.rect_w});
      write_reg(abrf_pkg::CSR_RECT_HEIGHT, {junk[31:16], s.rect_h});
      write_reg(abrf_pkg::CSR_FRAME_WIDTH, {junk[31:13], s.frame_w});
      write_reg(abrf_pkg::CSR_FRAME_HEIGHT, {junk[31:13], s.frame_h});
      write_reg(abrf_pkg::CSR_FILL_COLOR, s.color);
      write_reg(abrf_pkg::CSR_BLEND_ALPHA, {junk[31:8], s.alpha});
      csr_valid <= 1'b0;
      fill_setups++;
   endtask

   task automatic send_pixel(input logic [11:0] px, input logic [11:0] py,
                             input logic [31:0] dst);
      int gap;
      if (tx_bursty) begin
         if (burst_left == 0) begin
            gap = $urandom_range(1, 6);
            burst_left = $urandom_range(1, 12);
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left--;
      end
      req_tvalid <= 1'b1;
      req_tdata <= {dst, py, px};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      blend_queue.push_back(blend_pixel(px, py, dst));
      pixels_sent++;
   endtask

   task automatic wait_all_results();
      req_tvalid <= 1'b0;
      while (blend_queue.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic test_reset_state();
      tx_bursty = 1'b0;
      rx_style <= RX_ALWAYS;
      send_pixel(12'd0, 12'd0, 32'h0000_0000);
      send_pixel(12'hFFF, 12'hFFF, 32'hFFFF_FFFF);
      send_pixel(12'h555, 12'hAAA, 32'h5A5A_A5A5);
      wait_all_results();
   endtask

   task automatic test_clip_edges();
      rx_style <= RX_RANDOM;
      configure(make_setup(10, 20, 5, 3, 64, 64, 32'hA512_3456, abrf_pkg::ALPHA_OPAQUE));
      send_pixel(9, 20, 32'hFFFF_FFFF);
      send_pixel(10, 20, 32'h0000_0000);
      send_pixel(14, 22, 32'h1234_5678);
      send_pixel(15, 20, 32'h8765_4321);
      send_pixel(10, 19, 32'hFFFF_FFFF);
      send_pixel(10, 23, 32'h0000_0000);
      wait_all_results();
      configure(make_setup(-3, -1, 5, 2, 64, 64, 32'hFFFF_FFFF, abrf_pkg::ALPHA_OPAQUE));
      send_pixel(0, 0, 32'h0000_0000);
      send_pixel(1, 0, 32'h0000_0000);
      send_pixel(2, 0, 32'h0000_0000);
      wait_all_results();
      configure(make_setup(10, 20, 0, 3, 64, 64, 32'hFFFF_FFFF, abrf_pkg::ALPHA_OPAQUE));
      send_pixel(10, 20, 32'h0000_0000);
      wait_all_results();
      configure(make_setup(10, 20, 5, 0, 64, 64, 32'hFFFF_FFFF, abrf_pkg::ALPHA_OPAQUE));
      send_pixel(10, 20, 32'h0000_0000);
      wait_all_results();
   endtask

   task automatic test_extreme_geometry();
      rx_style <= RX_PATTERN;
      configure(make_setup(-32768, -32768, 65535, 65535, 4096, 4096, 32'h00FF_00FF,
                           abrf_pkg::ALPHA_OPAQUE));
      send_pixel(0, 0, 32'hFFFF_FFFF);
      send_pixel(4095, 4095, 32'h0000_0000);
      wait_all_results();
      configure(make_setup(32767, 32767, 65535, 65535, 8191, 8191, 32'hFFFF_FFFF,
                           abrf_pkg::ALPHA_OPAQUE));
      send_pixel(4095, 4095, 32'h0000_0000);
      wait_all_results();
      configure(make_setup(0, 0, 65535, 65535, 0, 0, 32'hFFFF_FFFF, abrf_pkg::ALPHA_OPAQUE));
      send_pixel(0, 0, 32'h0000_0000);
      wait_all_results();
      configure(make_setup(0, 0, 65535, 65535, 8191, 8191, 32'h8040_C020, 8'd77));
      send_pixel(4095, 4095, 32'hFFFF_FFFF);
      wait_all_results();
   endtask

   task automatic test_alpha_modes();
      rx_style <= RX_ALWAYS;
      configure(make_setup(0, 0, 16, 16, 16, 16, 32'hFFFF_FFFF, abrf_pkg::ALPHA_CLEAR));
      send_pixel(5, 5, 32'h0000_0000);
      wait_all_results();
      configure(make_setup(0, 0, 16, 16, 16, 16, 32'hFFFF_FFFF, 8'd1));
      send_pixel(5, 5, 32'h0000_0000);
      wait_all_results();
      configure(make_setup(0, 0, 16, 16, 16, 16, 32'h00FF_8000, 8'd128));
      send_pixel(15, 15, 32'h0000_FFFF);
      wait_all_results();
      configure(make_setup(0, 0, 16, 16, 16, 16, 32'h0000_0000, 8'd254));
      send_pixel(0, 15, 32'hFFFF_FFFF);
      wait_all_results();
      configure(make_setup(0, 0, 16, 16, 16, 16, 32'hFF00_0000, abrf_pkg::ALPHA_OPAQUE));
      send_pixel(15, 0, 32'h0000_0000);
      wait_all_results();
   endtask

   task automatic send_random_pixel();
      logic [11:0] px;
      logic [11:0] py;
      logic [31:0] dst;
      case ($urandom_range(0, 9))
         0: dst = 32'h0000_0000;
         1: dst = 32'hFFFF_FFFF;
         default: dst = $urandom();
      endcase
      if ($urandom_range(0, 9) < 3) begin
         px = 12'($urandom());
         py = 12'($urandom());
      end else begin
         px = near_span(fill_regs.rect_x, fill_regs.rect_w, fill_regs.frame_w);
         py = near_span(fill_regs.rect_y, fill_regs.rect_h, fill_regs.frame_h);
      end
      send_pixel(px, py, dst);
   endtask

   task automatic test_random_fills();
      int count;
      for (int phase = 0; phase < 12; phase++) begin
         configure(random_setup());
         tx_bursty = (phase % 4 != 0);
         case ($urandom_range(0, 2))
            0: rx_style <= (phase % 4 == 0) ? RX_ALWAYS : RX_PATTERN;
            1: rx_style <= RX_RANDOM;
            default: rx_style <= RX_PATTERN;
         endcase
         count = $urandom_range(45, 65);
         repeat (count) send_random_pixel();
         wait_all_results();
      end
   endtask

   task automatic test_drain_midstream();
      configure(random_setup());
      tx_bursty = 1'b1;
      rx_style <= RX_RANDOM;
      repeat (20) send_random_pixel();
      wait_all_results();
      repeat (20) send_random_pixel();
      wait_all_results();
   endtask

   always @(posedge clock) begin
      if ($urandom_range(0, 63) == 0) begin
         ready_pattern <= 16'($urandom()) | 16'h0001;
      end else begin
         ready_pattern <= {ready_pattern[0], ready_pattern[15:1]};
      end
      case (rx_style)
         RX_ALWAYS:  rsp_tready <= 1'b1;
         RX_PATTERN: rsp_tready <= ready_pattern[0];
         default:    rsp_tready <= ($urandom_range(0, 2) != 0);
      endcase
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (blend_queue.size() == 0) begin
            flag_mismatch($sformatf("result word %h with nothing pending", rsp_tdata));
         end else begin
            oldest = blend_queue.pop_front();
            if (rsp_tuser !== oldest.write_enable)
               flag_mismatch($sformatf("write_enable %b, want %b", rsp_tuser,
                                       oldest.write_enable));
            if (rsp_tdata[31:0] !== oldest.new_pixel)
               flag_mismatch($sformatf("new_pixel %h, want %h", rsp_tdata[31:0],
                                       oldest.new_pixel));
            if (rsp_tdata[55:32] !== oldest.address)
               flag_mismatch($sformatf("word_address %h, want %h", rsp_tdata[55:32],
                                       oldest.address));
            if (oldest.write_enable) begin
               writes_seen++;
               if (fill_regs.alpha == abrf_pkg::ALPHA_OPAQUE) opaque_seen++;
               else blends_seen++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results pending", cycle_count,
                  blend_queue.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_reset_state();
      test_clip_edges();
      test_extreme_geometry();
      test_alpha_modes();
      test_random_fills();
      test_drain_midstream();
      wait_all_results();
      repeat (8) @(posedge clock);
      if (blend_queue.size() != 0)
         flag_mismatch($sformatf("%0d results never arrived", blend_queue.size()));
      $display("Coverage: %0d pixels under %0d fill setups, %0d written back", pixels_sent,
               fill_setups, writes_seen);
      $display("Writes: %0d blended, %0d opaque; %0d mismatches", blends_seen, opaque_seen,
               error_count);
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/abrf_pkg.sv
rtl/alpha_blend_rect_fill.sv
rtl/abrf_checker.sv
bench/testbench.sv
